### design/pntpc_pkg.sv
// ----------------------------------------------------------------------------
// pntpc_pkg
// Types, register codes and arithmetic constants shared by the per-neighbor
// transmit power control block.
// ----------------------------------------------------------------------------
package pntpc_pkg;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_MAX_POWER   = 3'd0;
  localparam logic [2:0] REG_MIN_POWER   = 3'd1;
  localparam logic [2:0] REG_LCN_FLOOR   = 3'd2;
  localparam logic [2:0] REG_LCN_MODE    = 3'd3;
  localparam logic [2:0] REG_TARGET_RSSI = 3'd4;
  localparam logic [2:0] REG_HYSTERESIS  = 3'd5;
  localparam logic [2:0] REG_POWER_STEP  = 3'd6;

  // Result status codes.
  localparam logic [1:0] ST_EXISTING = 2'd0;
  localparam logic [1:0] ST_NEW      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // EWMA weights: the old average keeps 205/256, the sample brings 51/256.
  // The sample weight is pre-scaled by 256 for the x256 fixed point.
  localparam int SUM_W = 26;
  localparam logic signed [8:0]  EWMA_KEEP  = 9'sd205;
  localparam logic signed [15:0] EWMA_NEW_X = 16'sd13056;

  typedef struct packed {
    logic signed [5:0] max_power;
    logic signed [5:0] min_power;
    logic signed [5:0] lcn_floor;
    logic              lcn_mode;
    logic signed [7:0] target_rssi;
    logic [5:0]        hysteresis;
    logic [3:0]        power_step;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic fetch;
    logic mul;
    logic add;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_status_t;

  // Signed x256 value to whole units, truncated toward zero.
  function automatic logic signed [7:0] trunc256(input logic signed [15:0] v);
    logic signed [16:0] t;
    begin
      t = (v < 0) ? (17'(v) + 17'sd255) : 17'(v);
      trunc256 = 8'(t >>> 8);
    end
  endfunction

endpackage

### design/pntpc_regs.sv
// ----------------------------------------------------------------------------
// pntpc_regs
// APB configuration register file with read-back.
// ----------------------------------------------------------------------------
module pntpc_regs
  import pntpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_power   <= 6'sd0;
      cfg.min_power   <= -6'sd24;
      cfg.lcn_floor   <= -6'sd15;
      cfg.lcn_mode    <= 1'b0;
      cfg.target_rssi <= -8'sd85;
      cfg.hysteresis  <= 6'd6;
      cfg.power_step  <= 4'd1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_POWER:   cfg.max_power   <= $signed(pwdata[5:0]);
        REG_MIN_POWER:   cfg.min_power   <= $signed(pwdata[5:0]);
        REG_LCN_FLOOR:   cfg.lcn_floor   <= $signed(pwdata[5:0]);
        REG_LCN_MODE:    cfg.lcn_mode    <= pwdata[0];
        REG_TARGET_RSSI: cfg.target_rssi <= $signed(pwdata[7:0]);
        REG_HYSTERESIS:  cfg.hysteresis  <= pwdata[5:0];
        REG_POWER_STEP:  cfg.power_step  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_MAX_POWER:   prdata[5:0] = cfg.max_power;
      REG_MIN_POWER:   prdata[5:0] = cfg.min_power;
      REG_LCN_FLOOR:   prdata[5:0] = cfg.lcn_floor;
      REG_LCN_MODE:    prdata[0]   = cfg.lcn_mode;
      REG_TARGET_RSSI: prdata[7:0] = cfg.target_rssi;
      REG_HYSTERESIS:  prdata[5:0] = cfg.hysteresis;
      REG_POWER_STEP:  prdata[3:0] = cfg.power_step;
      default:         prdata      = '0;
    endcase
  end

endmodule

### design/pntpc_ctrl.sv
// ----------------------------------------------------------------------------
// pntpc_ctrl
// Sequencer: table scan, entry fetch, EWMA multiply, add, commit.
// ----------------------------------------------------------------------------
module pntpc_ctrl
  import pntpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  dp_status_t dp_status,
  output dp_cmd_t    dp_cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_ADD    = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          dp_cmd.load = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        dp_cmd.scan = 1'b1;
        if (dp_status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      // The compare of the last slot happens here, in the cycle after its read.
      S_DRAIN: state_next = S_FETCH;
      S_FETCH: begin
        dp_cmd.fetch = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        dp_cmd.mul = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        dp_cmd.add = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        dp_cmd.commit = 1'b1;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### design/pntpc_dp.sv
// ----------------------------------------------------------------------------
// pntpc_dp
// Neighbor table memories, scan compare, EWMA arithmetic and power stepping.
// ----------------------------------------------------------------------------
module pntpc_dp
  import pntpc_pkg::*;
#(
  parameter int NEIGHBOR_SLOTS = 32,
  parameter int ADDR_BITS      = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  dp_cmd_t           dp_cmd,
  output dp_status_t        dp_status,
  input  logic              req_type,
  input  logic [63:0]       neighbor_addr,
  input  logic signed [7:0] rssi_sample,
  output logic              done,
  output logic signed [7:0] link_power,
  output logic [1:0]        status,
  output logic signed [7:0] smoothed_rssi
);

  localparam int IDX_W = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NEIGHBOR_SLOTS - 1);

  logic [ADDR_BITS-1:0]    addr_mem  [NEIGHBOR_SLOTS];
  logic signed [15:0]      rssi_mem  [NEIGHBOR_SLOTS];
  logic signed [7:0]       power_mem [NEIGHBOR_SLOTS];
  logic [NEIGHBOR_SLOTS-1:0] slot_used;

  // Latched request.
  logic                 req_query;
  logic [ADDR_BITS-1:0] req_addr;
  logic signed [7:0]    req_sample;

  // Scan pipeline.
  logic [IDX_W-1:0]     scan_idx;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 cmp_vld;
  logic [ADDR_BITS-1:0] rd_addr;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     sel_idx;
  logic                 is_new;
  logic                 is_full;

  // Arithmetic stages.
  logic signed [15:0]      rd_rssi;
  logic signed [7:0]       rd_pow;
  logic signed [15:0]      avg_cur;
  logic signed [7:0]       pow_cur;
  logic signed [SUM_W-1:0] prod;
  logic signed [SUM_W-1:0] sterm;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_adj;
  logic signed [15:0]      avg_new;

  // Commit logic.
  logic signed [7:0] avg_whole;
  logic signed [9:0] err;
  logic signed [9:0] half_band;
  logic signed [8:0] p_dec;
  logic signed [8:0] p_inc;
  logic signed [8:0] floor_p;
  logic signed [8:0] max_p;
  logic signed [8:0] p_new;

  assign dp_status.scan_last = (scan_idx == LAST_IDX);
  assign sel_idx = hit ? hit_idx : free_idx;
  assign is_new  = !hit && free_found;
  assign is_full = !hit && !free_found;

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      req_query  <= req_type;
      req_addr   <= neighbor_addr[ADDR_BITS-1:0];
      req_sample <= rssi_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      cmp_vld    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      cmp_vld <= dp_cmd.scan;
      if (dp_cmd.load) begin
        scan_idx   <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (dp_cmd.scan && !dp_status.scan_last) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (cmp_vld) begin
          if (slot_used[cmp_idx] && (rd_addr == req_addr) && !hit) begin
            hit <= 1'b1;
          end
          if (!slot_used[cmp_idx] && !free_found) begin
            free_found <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.scan) begin
      rd_addr <= addr_mem[scan_idx];
      cmp_idx <= scan_idx;
    end
    if (cmp_vld) begin
      if (slot_used[cmp_idx] && (rd_addr == req_addr) && !hit) begin
        hit_idx <= cmp_idx;
      end
      if (!slot_used[cmp_idx] && !free_found) begin
        free_idx <= cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.fetch) begin
      rd_rssi <= rssi_mem[sel_idx];
      rd_pow  <= power_mem[sel_idx];
    end
  end

  // A new entry starts at the target RSSI and the maximum power.
  always_ff @(posedge clk) begin
    if (dp_cmd.mul) begin
      avg_cur <= is_new ? {cfg.target_rssi, 8'h00} : rd_rssi;
      pow_cur <= is_new ? 8'(cfg.max_power) : rd_pow;
      prod    <= SUM_W'(is_new ? $signed({cfg.target_rssi, 8'h00}) : rd_rssi)
                 * SUM_W'(EWMA_KEEP);
      sterm   <= SUM_W'(req_sample) * SUM_W'(EWMA_NEW_X);
    end
  end

  assign sum     = prod + sterm;
  assign sum_adj = (sum < 0) ? (sum + SUM_W'(255)) : sum;

  always_ff @(posedge clk) begin
    if (dp_cmd.add) begin
      avg_new <= req_query ? avg_cur : 16'(sum_adj >>> 8);
    end
  end

  assign avg_whole = trunc256(avg_new);
  assign err       = 10'(avg_whole) - 10'(cfg.target_rssi);
  assign half_band = $signed({5'b0, cfg.hysteresis[5:1]});
  assign max_p     = 9'(cfg.max_power);
  assign floor_p   = cfg.lcn_mode ? 9'(cfg.lcn_floor) : 9'(cfg.min_power);
  assign p_dec     = 9'(pow_cur) - $signed({5'b0, cfg.power_step});
  assign p_inc     = 9'(pow_cur) + $signed({5'b0, cfg.power_step});

  always_comb begin
    p_new = 9'(pow_cur);
    if (!req_query) begin
      if (err > half_band) begin
        p_new = (p_dec < floor_p) ? floor_p : p_dec;
      end else if (err < -half_band) begin
        p_new = (p_inc > max_p) ? max_p : p_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit && !is_full) begin
      rssi_mem[sel_idx]  <= avg_new;
      power_mem[sel_idx] <= p_new[7:0];
      if (is_new) begin
        addr_mem[sel_idx] <= req_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      done      <= 1'b0;
    end else begin
      done <= dp_cmd.commit;
      if (dp_cmd.commit && is_new) begin
        slot_used[sel_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      if (is_full) begin
        link_power    <= 8'(cfg.max_power);
        status        <= ST_FULL;
        smoothed_rssi <= '0;
      end else begin
        link_power    <= p_new[7:0];
        status        <= is_new ? ST_NEW : ST_EXISTING;
        smoothed_rssi <= avg_whole;
      end
    end
  end

endmodule

### design/per_neighbor_tx_power_control_top.sv
// ----------------------------------------------------------------------------
// per_neighbor_tx_power_control_top
// Per-neighbor transmit power control with a smoothed RSSI per neighbor.
// ----------------------------------------------------------------------------
// Usage:
//   Registers are to be written over the APB port only while the block is
//   idle (not enforced); pready is always high; reads return register values.
//   A request transfer happens on a clock edge with start high and busy low.
//   req_type, neighbor_addr and rssi_sample are sampled at that edge.
//   The table is scanned one slot per cycle through the address memory's
//   single read port; then the last compare, the entry fetch, the EWMA
//   multiply, the add and the commit follow, and the result is registered
//   at the commit. busy stays high until that result is shown; a new
//   request can be taken in the cycle in which the previous result is
//   shown, and not while busy is high.
//   Each result is shown for exactly one cycle with done high; the receiver
//   takes it in that cycle and cannot stall it.
//   Reset marks all table entries unused and restores the register defaults; no
//   clearing pass is needed, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module per_neighbor_tx_power_control_top
  import pntpc_pkg::*;
#(
  parameter int NEIGHBOR_SLOTS = 32,
  parameter int ADDR_BITS      = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type,
  input  logic [63:0]           neighbor_addr,
  input  logic signed [7:0]     rssi_sample,
  output logic                  done,
  output logic signed [7:0]     link_power,
  output logic [1:0]            status,
  output logic signed [7:0]     smoothed_rssi
);

  cfg_t       cfg;
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign pready = 1'b1;

  pntpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  pntpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  pntpc_dp #(
    .NEIGHBOR_SLOTS (NEIGHBOR_SLOTS),
    .ADDR_BITS      (ADDR_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .dp_cmd        (dp_cmd),
    .dp_status     (dp_status),
    .req_type      (req_type),
    .neighbor_addr (neighbor_addr),
    .rssi_sample   (rssi_sample),
    .done          (done),
    .link_power    (link_power),
    .status        (status),
    .smoothed_rssi (smoothed_rssi)
  );

endmodule

### design/pntpc_checker.sv
// ----------------------------------------------------------------------------
// pntpc_checker
// Port-level checks of the request and result timing, bound to the top level.
// ----------------------------------------------------------------------------
module pntpc_checker
  import pntpc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [1:0]        status,
  input logic signed [7:0] smoothed_rssi
);

  // A transfer always starts work.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request transfer did not raise busy");

  // A result is only shown once the item is finished.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // One result per item: results never come in adjacent cycles.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result repeated");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_EXISTING || status == ST_NEW || status == ST_FULL))
    else $error("undefined status code");

  a_full_rssi: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (smoothed_rssi == 8'sd0))
    else $error("full table result carries a nonzero RSSI");

endmodule

bind per_neighbor_tx_power_control_top pntpc_checker u_pntpc_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .smoothed_rssi (smoothed_rssi)
);
